FILE: src/tpq_pkg.sv
// ---------------------------------------------------------------------------
// tpq_pkg: shared types and constants for the timer pool / task queue
// Command and response payloads, operation codes and slot view types.
// ---------------------------------------------------------------------------
`default_nettype none

package tpq_pkg;

  localparam int QUEUE_DEPTH_DEF = 8;
  localparam int TIMER_SLOTS_DEF = 8;

  localparam logic [7:0] EMPTY_ID = 8'hFF;

  typedef enum logic [2:0] {
    OP_POST      = 3'd0,
    OP_TAKE      = 3'd1,
    OP_SET       = 3'd2,
    OP_STOP_RUN  = 3'd3,
    OP_GET       = 3'd4,
    OP_CLEAR     = 3'd5,
    OP_TICK      = 3'd6,
    OP_CLEAR_ALL = 3'd7
  } op_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  task_id;
    logic [15:0] time_value;
    logic        stop_flag;
  } cmd_t;

  typedef struct packed {
    logic        task_valid;
    logic [7:0]  task_out;
    logic [15:0] time_out;
    logic        accepted;
    logic [4:0]  queued_count;
    logic [5:0]  timer_count;
    logic [31:0] tick_count;
  } rsp_t;

  // write request into one timer slot
  typedef struct packed {
    logic        en;
    logic [7:0]  owner;
    logic [15:0] remaining;
    logic        stopped;
  } slot_wr_t;

  // one slot as seen by the sequencer, with the shared compare/decrement
  typedef struct packed {
    logic [7:0]  owner;
    logic [15:0] remaining;
    logic        stopped;
    logic        match;
    logic        is_free;
    logic [15:0] dec;
    logic        expire;
  } slot_view_t;

endpackage

`default_nettype wire

FILE: src/tpq_ring.sv
// ---------------------------------------------------------------------------
// tpq_ring: ring of ready task IDs
// One push at the tail or one pop at the head per cycle; pushes into a
// full ring are dropped.
// ---------------------------------------------------------------------------
`default_nettype none

module tpq_ring
  import tpq_pkg::*;
#(
  parameter int Depth = QUEUE_DEPTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         clear,
  input  wire logic                         push,
  input  wire logic [7:0]                   push_id,
  input  wire logic                         pop,
  output logic      [7:0]                   head_id,
  output logic      [$clog2(Depth+1)-1:0]   count
);

  localparam int PW = $clog2(Depth);
  localparam int CW = $clog2(Depth + 1);

  logic [7:0]    slots [Depth];
  logic [PW-1:0] head;
  logic [PW-1:0] tail;
  logic          full;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(Depth));
  assign do_push = push && !full;
  assign do_pop  = pop && (count != '0);
  assign head_id = slots[head];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else if (do_push) begin
      tail  <= (tail == PW'(Depth - 1)) ? '0 : tail + 1'b1;
      count <= count + 1'b1;
    end else if (do_pop) begin
      head  <= (head == PW'(Depth - 1)) ? '0 : head + 1'b1;
      count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push && !clear) begin
      slots[tail] <= push_id;
    end
  end

endmodule

`default_nettype wire

FILE: src/tpq_timer_bank.sv
// ---------------------------------------------------------------------------
// tpq_timer_bank: pool of one-shot countdown timers
// Holds owner, remaining time and stop flag per slot; presents one slot at
// a time through the shared owner compare and decrement.
// ---------------------------------------------------------------------------
`default_nettype none

module tpq_timer_bank
  import tpq_pkg::*;
#(
  parameter int Slots = TIMER_SLOTS_DEF,
  localparam int IW   = (Slots > 1) ? $clog2(Slots) : 1
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          clear,
  input  wire logic [IW-1:0] rd_idx,
  input  wire logic [7:0]    task_id,
  input  wire logic [IW-1:0] wr_idx,
  input  wire slot_wr_t      wr,
  output slot_view_t         view
);

  logic [7:0]  owner     [Slots];
  logic [15:0] remaining [Slots];
  logic        stopped   [Slots];

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      for (int i = 0; i < Slots; i++) begin
        owner[i]     <= EMPTY_ID;
        remaining[i] <= '0;
        stopped[i]   <= 1'b1;
      end
    end else if (wr.en) begin
      owner[wr_idx]     <= wr.owner;
      remaining[wr_idx] <= wr.remaining;
      stopped[wr_idx]   <= wr.stopped;
    end
  end

  always_comb begin
    view.owner     = owner[rd_idx];
    view.remaining = remaining[rd_idx];
    view.stopped   = stopped[rd_idx];
    view.is_free   = (view.owner == EMPTY_ID);
    // the empty mark never matches a slot
    view.match     = (view.owner == task_id) && !view.is_free;
    view.dec       = view.remaining - 16'd1;
    view.expire    = !view.is_free && !view.stopped && (view.remaining == 16'd1);
  end

endmodule

`default_nettype wire

FILE: src/timer_pool_task_queue_unit.sv
// ---------------------------------------------------------------------------
// timer_pool_task_queue_unit: task ready ring with a pool of one-shot timers
// Sequencer that walks the timer slots through one shared compare/decrement.
// ---------------------------------------------------------------------------
// Usage:
//   Drive request and raise start; the command transfers at a clock edge
//   with start high and busy low. busy stays high until the result is out.
//   The result appears on response for exactly one cycle with done high;
//   the receiver takes it in that cycle and cannot hold it off.
// Steps from the transfer edge to the done cycle:
//   post, take, clear all, and set with the empty task ID: the S_SHORT state.
//   set, stop/run, get, clear timer: the walk over the timer slots, one slot
//   per cycle, stops at the owner's slot or after the last slot.
//   tick: the walk always visits every slot.
//   A new command can transfer in the cycle after done.
// Reset (synchronous, active high) empties the ring, frees every timer and
//   zeroes the tick counter; the block is idle the cycle after.
// Expired timers post their task IDs in slot order during the tick walk.
// ---------------------------------------------------------------------------
`default_nettype none

module timer_pool_task_queue_unit
  import tpq_pkg::*;
#(
  parameter int QueueDepth = QUEUE_DEPTH_DEF,
  parameter int TimerSlots = TIMER_SLOTS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic start,
  input  wire cmd_t request,
  output logic      busy,
  output logic      done,
  output rsp_t      response
);

  localparam int IW = (TimerSlots > 1) ? $clog2(TimerSlots) : 1;
  localparam int QC = $clog2(QueueDepth + 1);
  localparam int UW = $clog2(TimerSlots + 1);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_SHORT = 4'b0010,
    S_WALK  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  state_t        state;
  state_t        state_next;
  cmd_t          cmd;
  logic [IW-1:0] idx;
  logic [IW-1:0] free_idx;
  logic          have_free;
  logic [UW-1:0] used;
  logic [31:0]   ticks;

  logic          task_valid;
  logic [7:0]    task_out;
  logic [15:0]   time_out;
  logic          accepted;

  logic          ring_clear;
  logic          ring_push;
  logic [7:0]    ring_push_id;
  logic          ring_pop;
  logic [7:0]    ring_head;
  logic [QC-1:0] ring_count;

  slot_wr_t      wr;
  logic [IW-1:0] wr_idx;
  slot_view_t    cur;

  logic          last;
  logic          finish;
  logic          used_inc;
  logic          used_dec;
  logic          set_acc;
  logic          set_time;
  logic          take_ok;
  logic          post_ok;

  tpq_ring #(
    .Depth (QueueDepth)
  ) u_ring (
    .clk     (clk),
    .rst     (rst),
    .clear   (ring_clear),
    .push    (ring_push),
    .push_id (ring_push_id),
    .pop     (ring_pop),
    .head_id (ring_head),
    .count   (ring_count)
  );

  tpq_timer_bank #(
    .Slots (TimerSlots)
  ) u_bank (
    .clk     (clk),
    .rst     (rst),
    .clear   (ring_clear),
    .rd_idx  (idx),
    .task_id (cmd.task_id),
    .wr_idx  (wr_idx),
    .wr      (wr),
    .view    (cur)
  );

  assign last    = (idx == IW'(TimerSlots - 1));
  assign post_ok = (cmd.task_id != EMPTY_ID) && (ring_count != QC'(QueueDepth));
  assign take_ok = (ring_count != '0);

  // one step of the sequencer: short commands and one slot of a walk
  always_comb begin
    ring_clear   = 1'b0;
    ring_push    = 1'b0;
    ring_push_id = cmd.task_id;
    ring_pop     = 1'b0;
    wr           = '0;
    wr_idx       = idx;
    finish       = 1'b0;
    used_inc     = 1'b0;
    used_dec     = 1'b0;
    set_acc      = 1'b0;
    set_time     = 1'b0;

    if (state == S_SHORT) begin
      unique case (cmd.op)
        OP_POST:      ring_push  = post_ok;
        OP_TAKE:      ring_pop   = take_ok;
        OP_CLEAR_ALL: ring_clear = 1'b1;
        default:      ;
      endcase
    end else if (state == S_WALK) begin
      unique case (cmd.op)
        OP_SET: begin
          if (cur.match) begin
            set_acc = 1'b1;
            finish  = 1'b1;
            wr.en   = 1'b1;
            if (cmd.time_value == '0) begin
              wr.owner     = EMPTY_ID;
              wr.remaining = '0;
              wr.stopped   = 1'b1;
              used_dec     = 1'b1;
            end else begin
              wr.owner     = cur.owner;
              wr.remaining = cmd.time_value;
              wr.stopped   = 1'b0;
            end
          end else if (last) begin
            finish = 1'b1;
            if (have_free || cur.is_free) begin
              // claim the first free slot seen during the walk
              set_acc      = 1'b1;
              used_inc     = 1'b1;
              wr.en        = 1'b1;
              wr_idx       = have_free ? free_idx : idx;
              wr.owner     = cmd.task_id;
              wr.remaining = cmd.time_value;
              wr.stopped   = 1'b0;
            end
          end
        end
        OP_STOP_RUN, OP_GET, OP_CLEAR: begin
          if (cur.match) begin
            set_acc  = 1'b1;
            set_time = (cmd.op == OP_GET);
            finish   = 1'b1;
            if (cmd.op == OP_STOP_RUN) begin
              wr.en        = 1'b1;
              wr.owner     = cur.owner;
              wr.remaining = cur.remaining;
              wr.stopped   = cmd.stop_flag;
            end else if (cmd.op == OP_CLEAR) begin
              wr.en        = 1'b1;
              wr.owner     = EMPTY_ID;
              wr.remaining = '0;
              wr.stopped   = 1'b1;
              used_dec     = 1'b1;
            end
          end else if (last) begin
            finish = 1'b1;
          end
        end
        OP_TICK: begin
          finish = last;
          if (!cur.is_free && !cur.stopped) begin
            wr.en = 1'b1;
            if (cur.expire) begin
              // post the owner and free the slot even if the post drops
              ring_push    = 1'b1;
              ring_push_id = cur.owner;
              wr.owner     = EMPTY_ID;
              wr.remaining = '0;
              wr.stopped   = 1'b1;
              used_dec     = 1'b1;
            end else begin
              wr.owner     = cur.owner;
              wr.remaining = cur.dec;
              wr.stopped   = 1'b0;
            end
          end
        end
        default: finish = 1'b1;
      endcase
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (request.op)
            OP_POST, OP_TAKE, OP_CLEAR_ALL: state_next = S_SHORT;
            OP_SET: state_next = (request.task_id == EMPTY_ID) ? S_SHORT : S_WALK;
            default: state_next = S_WALK;
          endcase
        end
      end
      S_SHORT: state_next = S_DONE;
      S_WALK:  state_next = finish ? S_DONE : S_WALK;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      ticks <= '0;
    end else begin
      state <= state_next;
      if (ring_clear) begin
        used <= '0;
      end else if (used_inc) begin
        used <= used + 1'b1;
      end else if (used_dec && used != '0) begin
        used <= used - 1'b1;
      end
      if (state == S_WALK && cmd.op == OP_TICK && finish) begin
        ticks <= ticks + 32'd1;
      end
    end
  end

  // command hold, walk index and result fields
  always_ff @(posedge clk) begin
    if (state == S_IDLE && start) begin
      cmd        <= request;
      idx        <= '0;
      have_free  <= 1'b0;
      free_idx   <= '0;
      task_valid <= 1'b0;
      task_out   <= EMPTY_ID;
      time_out   <= '0;
      accepted   <= 1'b0;
    end else if (state == S_SHORT) begin
      if (cmd.op == OP_POST) begin
        accepted <= post_ok;
      end else if (cmd.op == OP_TAKE && take_ok) begin
        task_valid <= 1'b1;
        task_out   <= ring_head;
      end
    end else if (state == S_WALK) begin
      if (!last) begin
        idx <= idx + 1'b1;
      end
      if (cur.is_free && !have_free) begin
        have_free <= 1'b1;
        free_idx  <= idx;
      end
      if (set_acc) begin
        accepted <= 1'b1;
      end
      if (set_time) begin
        time_out <= cur.remaining;
      end
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

  always_comb begin
    response.task_valid   = task_valid;
    response.task_out     = task_out;
    response.time_out     = time_out;
    response.accepted     = accepted;
    response.queued_count = 5'(ring_count);
    response.timer_count  = 6'(used);
    response.tick_count   = ticks;
  end

endmodule

`default_nettype wire
